/* rtl/rbb_pkg.sv */
// ----------------------------------------------------------------------------
// rbb_pkg: shared types and helpers for the RGB 3x3 box blur
// Pixel and channel types, per-word flags and the divide-by-nine helper.
// ----------------------------------------------------------------------------
package rbb_pkg;

  typedef logic [23:0] pix_t;
  typedef logic [7:0]  chan_t;
  typedef logic [11:0] sum_t;
  typedef logic [11:0] row_t;

  // Which results a pixel word causes
  typedef struct packed {
    logic has_a;   // window centre (r-1, c-1)
    logic a_pass;  // window centre sits on the first row or column
    logic has_b;   // end of the row above (r-1, c)
    logic has_c;   // last-row pixel itself (r, c)
  } rbb_flags_t;

  // Reciprocal of nine in 0.16 fixed point, exact for sums up to 2295
  localparam logic [12:0] DIV9_RECIP = 13'd7282;

  function automatic chan_t div9(input sum_t s);
    logic [24:0] prod;
    prod = 25'(s) * 25'(DIV9_RECIP);
    return prod[23:16];
  endfunction

endpackage

/* rtl/rgb_box_blur_3x3_unit.sv */
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_unit: streaming 3x3 box blur of RGB pixels
// Each accepted pixel passes stage one and the sequencer; its result words then
// leave the output register in order, one per cycle while out_tready is high.
// Throughput: 1 pixel per cycle while out_tready is high; a pixel holds the input
// until all but its last result word are out: two words at the last column below
// row 0 or on the last row (one at its first column), three at the last column of
// the last row. Reset clears counters, valid flags and window, not the line store.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_unit
  import rbb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [12:0] cfg_wdata,
  // pixel stream in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue_in, green_in, red_in
  // result stream out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [((36 + $clog2(MAX_WIDTH) + 7) / 8) * 8 - 1:0] out_tdata,
                                  // out_col, out_row, blue_out, green_out, red_out
  output logic        out_tlast   // run_last
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = (COL_W + 1 > 11) ? COL_W + 1 : 11;
  localparam int OUT_DW = ((36 + COL_W + 7) / 8) * 8;
  localparam int PAD_W  = OUT_DW - 36 - COL_W;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  logic [10:0]      fw_r;
  logic [12:0]      fh_r;
  logic [WW-1:0]    fw_ext;
  logic [WW-1:0]    w_eff;
  logic [12:0]      h_eff;

  row_t             row_r;
  logic [COL_W-1:0] col_r;
  logic             wrap;
  row_t             r_cur;
  logic [COL_W-1:0] c_cur;
  logic             last_col;
  logic             last_row;
  rbb_flags_t       flags_cur;

  logic             in_fire;
  logic             adv;
  logic             s1_move;

  logic             v1_r;
  pix_t             px1_r;
  row_t             r1_r;
  logic [COL_W-1:0] c1_r;
  rbb_flags_t       flags1_r;

  logic [47:0]      rd_word;
  pix_t             older_rd;
  pix_t             newer_rd;
  pix_t             win_r [6];
  sum_t [2:0]       sums;

  pix_t             res_pix;
  row_t             res_row;
  logic [COL_W-1:0] res_col;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 11'd1024;
      fh_r <= 13'd768;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  fw_r <= cfg_wdata[10:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        default:          fw_r <= fw_r;
      endcase
    end
  end

  // Saturate frame size to the supported range
  assign fw_ext = WW'(fw_r);
  assign w_eff  = (fw_ext < WW'(3)) ? WW'(3) :
                  (fw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : fw_ext;
  assign h_eff  = (fh_r < 13'd3) ? 13'd3 : (fh_r > 13'd4096) ? 13'd4096 : fh_r;

  // Raster position of the incoming word
  assign wrap     = (WW'(col_r) >= w_eff) || (13'(row_r) >= h_eff);
  assign r_cur    = wrap ? '0 : row_r;
  assign c_cur    = wrap ? '0 : col_r;
  assign last_col = (WW'(c_cur) + WW'(1)) >= w_eff;
  assign last_row = (13'(r_cur) + 13'd1) >= h_eff;

  assign flags_cur.has_a  = (r_cur != '0) && (c_cur != '0);
  assign flags_cur.a_pass = (r_cur == row_t'(1)) || (c_cur == COL_W'(1));
  assign flags_cur.has_b  = (r_cur != '0) && last_col;
  assign flags_cur.has_c  = last_row;

  // Handshake: stage one moves on when the sequencer frees up
  assign s1_move   = v1_r && adv;
  assign in_tready = !v1_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  // Advance the raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : r_cur + row_t'(1);
      end else begin
        col_r <= c_cur + COL_W'(1);
        row_r <= r_cur;
      end
    end
  end

  // Stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      px1_r    <= in_tdata;
      r1_r     <= r_cur;
      c1_r     <= c_cur;
      flags1_r <= flags_cur;
    end
  end

  // Line store: read on accept, write back when the word leaves stage one.
  // Consecutive words sit at different columns, so the read and the write
  // of one edge never meet at the same entry.
  rbb_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W),
    .DW    (48)
  ) u_line_mem (
    .clk     (clk),
    .we      (s1_move),
    .waddr   (c1_r),
    .wdata   ({px1_r, newer_rd}),
    .re      (in_fire),
    .raddr   (c_cur),
    .rdata_r (rd_word)
  );

  assign older_rd = rd_word[23:0];
  assign newer_rd = rd_word[47:24];

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_move) begin
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= older_rd;
      win_r[1] <= newer_rd;
      win_r[2] <= px1_r;
    end
  end

  // Nine-byte sums per channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sums[k] = sum_t'(win_r[0][8*k +: 8]) + sum_t'(win_r[1][8*k +: 8])
              + sum_t'(win_r[2][8*k +: 8]) + sum_t'(win_r[3][8*k +: 8])
              + sum_t'(win_r[4][8*k +: 8]) + sum_t'(win_r[5][8*k +: 8])
              + sum_t'(older_rd[8*k +: 8]) + sum_t'(newer_rd[8*k +: 8])
              + sum_t'(px1_r[8*k +: 8]);
    end
  end

  rbb_emit #(
    .COL_W (COL_W)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (v1_r),
    .flags     (flags1_r),
    .row       (r1_r),
    .col       (c1_r),
    .sums      (sums),
    .pass_a    (win_r[1]),
    .pass_b    (newer_rd),
    .pass_c    (px1_r),
    .adv       (adv),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (res_pix),
    .out_row   (res_row),
    .out_col   (res_col),
    .out_last  (out_tlast)
  );

  // Pack the result word
  generate
    if (PAD_W > 0) begin : g_pad
      assign out_tdata = {{PAD_W{1'b0}}, res_col, res_row, res_pix};
    end else begin : g_nopad
      assign out_tdata = {res_col, res_row, res_pix};
    end
  endgenerate

endmodule

/* rtl/rbb_line_mem.sv */
// ----------------------------------------------------------------------------
// rbb_line_mem: line store
// Simple dual-port synchronous RAM holding both previous rows per column,
// one write port, one read port with a registered read word.
// ----------------------------------------------------------------------------
module rbb_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  // Write one column entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one column entry, hold the word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* rtl/rbb_emit.sv */
// ----------------------------------------------------------------------------
// rbb_emit: result sequencer and output register
// Holds the sums and pass-through pixels of one word, divides by nine and
// hands out up to three result words in order through a registered output.
// ----------------------------------------------------------------------------
module rbb_emit
  import rbb_pkg::*;
#(
  parameter int COL_W = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  // word from the window stage
  input  logic                load,
  input  rbb_flags_t          flags,
  input  row_t                row,
  input  logic [COL_W-1:0]    col,
  input  sum_t [2:0]          sums,
  input  pix_t                pass_a,
  input  pix_t                pass_b,
  input  pix_t                pass_c,
  output logic                adv,
  // result stream
  output logic                out_valid,
  input  logic                out_ready,
  output pix_t                out_pix,
  output row_t                out_row,
  output logic [COL_W-1:0]    out_col,
  output logic                out_last
);

  logic [2:0]       mask_r;
  logic             a_pass_r;
  sum_t [2:0]       sum_r;
  pix_t             pa_r, pb_r, pc_r;
  row_t             row_r;
  logic [COL_W-1:0] col_r;

  logic             out_valid_r;
  pix_t             out_pix_r;
  row_t             out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r;

  logic             slot_free;
  logic             fire;
  logic             single;
  logic [2:0]       lowest;
  pix_t             mean_pix;
  pix_t             sel_pix;
  row_t             sel_row;
  logic [COL_W-1:0] sel_col;

  assign slot_free = !out_valid_r || out_ready;
  assign fire      = (mask_r != 3'b000) && slot_free;
  assign single    = ((mask_r & (mask_r - 3'd1)) == 3'b000);
  assign lowest    = mask_r & (~mask_r + 3'd1);
  assign adv       = (mask_r == 3'b000) || (fire && single);

  assign mean_pix = {div9(sum_r[2]), div9(sum_r[1]), div9(sum_r[0])};

  // Pick the earliest pending result
  always_comb begin
    priority if (mask_r[0]) begin
      sel_pix = a_pass_r ? pa_r : mean_pix;
      sel_row = row_r - row_t'(1);
      sel_col = col_r - COL_W'(1);
    end else if (mask_r[1]) begin
      sel_pix = pb_r;
      sel_row = row_r - row_t'(1);
      sel_col = col_r;
    end else begin
      sel_pix = pc_r;
      sel_row = row_r;
      sel_col = col_r;
    end
  end

  // Track pending results of the held word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 3'b000;
    end else if (adv) begin
      mask_r <= load ? {flags.has_c, flags.has_b, flags.has_a} : 3'b000;
    end else if (fire) begin
      mask_r <= mask_r & ~lowest;
    end
  end

  // Capture the word payload
  always_ff @(posedge clk) begin
    if (adv && load) begin
      a_pass_r <= flags.a_pass;
      sum_r    <= sums;
      pa_r     <= pass_a;
      pb_r     <= pass_b;
      pc_r     <= pass_c;
      row_r    <= row;
      col_r    <= col;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= (mask_r != 3'b000);
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_pix_r  <= sel_pix;
      out_row_r  <= sel_row;
      out_col_r  <= sel_col;
      out_last_r <= single;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

endmodule
